FILE: rtl/core/stu_pkg.sv
// Shared types, character constants and digit decode for the string-to-unsigned parser.
package stu_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int CHAR_BITS          = 8;
    localparam int BASE_BITS          = 6;
    localparam int OUT_VALUE_BITS     = 32;
    localparam int ADDR_BITS          = 3;
    localparam int DATA_BITS          = 32;

    // Register index decoded from the word address bit
    localparam logic REG_NUMBER_BASE = 1'b0;

    localparam logic [BASE_BITS-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_OCTAL   = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DECIMAL = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_BITS-1:0] NOT_DIGIT    = 6'd63;

    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_VTAB    = 8'h0B;
    localparam logic [CHAR_BITS-1:0] CH_FORMFD  = 8'h0C;
    localparam logic [CHAR_BITS-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_X = 8'h78;
    // Letter offsets so that 'A' and 'a' map to digit value ten
    localparam logic [CHAR_BITS-1:0] UPPER_OFFSET = 8'd55;
    localparam logic [CHAR_BITS-1:0] LOWER_OFFSET = 8'd87;

    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
               (c == CH_VTAB) || (c == CH_FORMFD) || (c == CH_RETURN);
    endfunction

    function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] diff;
        diff = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            diff = c - CH_ZERO;
            return diff[BASE_BITS-1:0];
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            diff = c - UPPER_OFFSET;
            return diff[BASE_BITS-1:0];
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            diff = c - LOWER_OFFSET;
            return diff[BASE_BITS-1:0];
        end
        return NOT_DIGIT;
    endfunction

endpackage

FILE: rtl/core/string_to_unsigned_parser.sv
// Top level of the streaming string-to-unsigned parser.
//
//   group    dir   payload                                   beat ends
//   s_axis   in    tdata[7:0] character, tlast last          every beat
//   m_axis   out   tdata[31:0] value, tuser[0] overflowed,   one per string
//                  tuser[1] digits_seen
//   apb      in    0x0 number_base[5:0]                      write access phase
//
// One character per clock while s_axis_tready is high; the multiply-accumulate on the digit path sets the cycle.
// A result appears in the cycle after the beat carrying tlast and sits in the output register.
// Input is held off only while that register is full and m_axis_tready is low.
// Reset restores base ten and an empty string; no clearing pass is needed.
module string_to_unsigned_parser #(
    parameter int VALUE_BITS = stu_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [stu_pkg::CHAR_BITS-1:0]     s_axis_tdata,   // [7:0] character
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [stu_pkg::OUT_VALUE_BITS-1:0] m_axis_tdata,  // [31:0] value
    output logic [1:0]                        m_axis_tuser,   // [0] overflowed, [1] digits_seen
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stu_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [stu_pkg::DATA_BITS-1:0]     pwdata,
    output logic [stu_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready
);
    import stu_pkg::*;

    localparam int PROD_BITS = VALUE_BITS + BASE_BITS + 1;
    localparam int EXT_BITS  = (VALUE_BITS > OUT_VALUE_BITS) ? VALUE_BITS : OUT_VALUE_BITS;

    logic [BASE_BITS-1:0]  number_base_reg;
    phase_t                phase_reg, phase_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic                  ovf_reg, ovf_next;
    logic                  any_reg, any_next;
    logic [BASE_BITS-1:0]  base_reg, base_next;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic                  out_ovf_reg;
    logic                  out_digits_reg;

    logic                  s_fire;
    logic                  cfg_write;
    logic [BASE_BITS-1:0]  first_base;
    logic [BASE_BITS-1:0]  digit_base;
    logic [BASE_BITS-1:0]  digit;
    logic                  digit_ok;
    logic [PROD_BITS-1:0]  prod;
    logic                  prod_ovf;
    logic                  run_digit;
    logic                  auto_prefix;
    logic [EXT_BITS-1:0]   value_ext;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[ADDR_BITS-1] == REG_NUMBER_BASE)
                       ? DATA_BITS'(number_base_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            number_base_reg <= BASE_DECIMAL;
        else if (cfg_write && paddr[ADDR_BITS-1] == REG_NUMBER_BASE)
            number_base_reg <= pwdata[BASE_BITS-1:0];
    end

    // Handshake: take a beat unless a finished result is stuck in the output register
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Digit path: one multiply-accumulate, overflow from the widened product
    assign first_base  = (number_base_reg == BASE_AUTO) ? BASE_DECIMAL : number_base_reg;
    assign auto_prefix = ((number_base_reg == BASE_AUTO) || (number_base_reg == BASE_HEX)) &&
                         (s_axis_tdata == CH_ZERO);
    assign digit_base  = (phase_reg == PH_SKIP || phase_reg == PH_SIGNED) ? first_base
                                                                          : base_reg;
    assign digit       = digit_of(s_axis_tdata);
    assign digit_ok    = (digit != NOT_DIGIT) && (digit < digit_base) &&
                         (digit_base != BASE_AUTO);
    assign prod        = PROD_BITS'(acc_reg) * PROD_BITS'(digit_base) + PROD_BITS'(digit);
    assign prod_ovf    = |prod[PROD_BITS-1:VALUE_BITS];

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        any_next   = any_reg;
        base_next  = base_reg;
        run_digit  = 1'b0;

        unique case (phase_reg)
            PH_SKIP, PH_SIGNED:
            begin
                if (phase_reg == PH_SKIP && is_blank(s_axis_tdata))
                begin
                    phase_next = PH_SKIP;
                end
                else if (phase_reg == PH_SKIP && s_axis_tdata == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGNED;
                end
                else if (phase_reg == PH_SKIP && s_axis_tdata == CH_PLUS)
                begin
                    phase_next = PH_SIGNED;
                end
                else if (auto_prefix)
                begin
                    base_next  = (number_base_reg == BASE_AUTO) ? BASE_OCTAL : BASE_HEX;
                    acc_next   = '0;
                    any_next   = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_next = first_base;
                    run_digit = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (s_axis_tdata == CH_LOWER_X || s_axis_tdata == CH_UPPER_X)
                begin
                    base_next  = BASE_HEX;
                    acc_next   = '0;
                    any_next   = 1'b0;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    run_digit = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                run_digit = 1'b1;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (run_digit)
        begin
            if (!digit_ok)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_DIGITS;
                if (!ovf_reg)
                begin
                    if (prod_ovf)
                        ovf_next = 1'b1;
                    else
                        acc_next = prod[VALUE_BITS-1:0];
                    any_next = 1'b1;
                end
            end
        end
    end

    // Saturate on overflow, else apply the sign modulo the value width
    always_comb
    begin
        if (ovf_next)
            out_value_next = {VALUE_BITS{1'b1}};
        else if (neg_next)
            out_value_next = VALUE_BITS'(0) - acc_next;
        else
            out_value_next = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            any_reg   <= 1'b0;
            base_reg  <= BASE_DECIMAL;
        end
        else if (s_fire)
        begin
            if (s_axis_tlast)
            begin
                // End of string: drop all per-string state
                phase_reg <= PH_SKIP;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
                any_reg   <= 1'b0;
                base_reg  <= BASE_DECIMAL;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                ovf_reg   <= ovf_next;
                any_reg   <= any_next;
                base_reg  <= base_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_fire && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && s_axis_tlast)
        begin
            out_value_reg  <= out_value_next;
            out_ovf_reg    <= ovf_next;
            out_digits_reg <= any_next || ovf_next;
        end
    end

    assign value_ext     = EXT_BITS'(out_value_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_ext[OUT_VALUE_BITS-1:0];
    assign m_axis_tuser  = {out_digits_reg, out_ovf_reg};

    // Checks
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tlast) |=> (phase_reg == PH_SKIP && acc_reg == '0 && !ovf_reg))
        else $error("string state not cleared after last beat");

    a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |-> (out_value_reg == {VALUE_BITS{1'b1}}))
        else $error("overflowed result is not saturated");

    a_ovf_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("overflow reported without digits");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (out_valid_reg && !m_axis_tready))
        else $error("input held off without a blocked result");

    a_base_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg != BASE_AUTO)
        else $error("working radix is zero");

endmodule
